### rtl/core/css_subset_tokenizer_defines.svh
// Assertion macros used by the tokenizer top level.
`ifndef CSS_SUBSET_TOKENIZER_DEFINES_SVH
`define CSS_SUBSET_TOKENIZER_DEFINES_SVH

// Clocked assertion that is ignored while reset is asserted.
`define CSS_TOK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that must also hold while reset is asserted.
`define CSS_TOK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/css_tok_pkg.sv
// Types and constants for the CSS subset tokenizer.
package css_tok_pkg;

  localparam int unsigned MaxDesc    = 3;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = 2;

  // Token kinds as carried in token_kind.
  localparam logic [3:0] KindDot    = 4'd0;
  localparam logic [3:0] KindHash   = 4'd1;
  localparam logic [3:0] KindColon  = 4'd2;
  localparam logic [3:0] KindComma  = 4'd3;
  localparam logic [3:0] KindSemi   = 4'd4;
  localparam logic [3:0] KindLbrace = 4'd5;
  localparam logic [3:0] KindRbrace = 4'd6;
  localparam logic [3:0] KindIdent  = 4'd7;
  localparam logic [3:0] KindValue  = 4'd8;

  // Character codes.
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_IDENT   = 5'b00010,
    MODE_VALUE   = 5'b00100,
    MODE_COMMENT = 5'b01000,
    MODE_STAR    = 5'b10000
  } mode_e;

  typedef enum logic [3:0] {
    PEND_NONE      = 4'b0001,
    PEND_SLASH     = 4'b0010,
    PEND_DOT_IDLE  = 4'b0100,
    PEND_DOT_VALUE = 4'b1000
  } pend_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_source;
  } in_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] start_offset;
    logic [16:0] token_length;
    logic        last_of_run;
    logic        too_long;
  } out_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [16:0] length;
  } desc_t;

  // All descriptors caused by one source byte.
  typedef struct packed {
    desc_t [MaxDesc-1:0] slot;
    logic [1:0]          count;
    logic                too_long;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/core/css_tok_front.sv
// Front end: scans one byte per cycle while accept_i is high and builds its descriptor bundle.
module css_tok_front #(
  parameter int unsigned MAX_SOURCE = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  css_tok_pkg::in_t     req_i,
  output logic                 push_o,
  output css_tok_pkg::bundle_t bundle_o
);

  localparam logic [16:0] PosLimit = 17'((MAX_SOURCE < 65536) ? MAX_SOURCE : 65536);

  css_tok_pkg::mode_e mode_q, mode_d;
  css_tok_pkg::pend_e pend_q, pend_d;
  logic [16:0] poff_q, poff_d;
  logic [16:0] rs_q, rs_d;
  logic [16:0] pos_q, pos_d;
  logic        ovf_q, ovf_d;
  logic [16:0] p;
  logic [7:0]  b;
  logic        do_vmore, do_start;
  css_tok_pkg::bundle_t bd;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic ident_start(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c == css_tok_pkg::ChUnder) || (c == css_tok_pkg::ChMinus);
  endfunction

  function automatic logic ident_char(input logic [7:0] c);
    return ident_start(c) || is_digit(c);
  endfunction

  function automatic logic punct_hit(input logic [7:0] c);
    return (c == css_tok_pkg::ChDot) || (c == css_tok_pkg::ChHash) ||
           (c == css_tok_pkg::ChColon) || (c == css_tok_pkg::ChComma) ||
           (c == css_tok_pkg::ChSemi) || (c == css_tok_pkg::ChLbrace) ||
           (c == css_tok_pkg::ChRbrace);
  endfunction

  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      css_tok_pkg::ChHash:   k = css_tok_pkg::KindHash;
      css_tok_pkg::ChColon:  k = css_tok_pkg::KindColon;
      css_tok_pkg::ChComma:  k = css_tok_pkg::KindComma;
      css_tok_pkg::ChSemi:   k = css_tok_pkg::KindSemi;
      css_tok_pkg::ChLbrace: k = css_tok_pkg::KindLbrace;
      css_tok_pkg::ChRbrace: k = css_tok_pkg::KindRbrace;
      default:               k = css_tok_pkg::KindDot;
    endcase
    return k;
  endfunction

  function automatic logic value_char(input logic [7:0] c);
    return !punct_hit(c) && !is_space(c);
  endfunction

  // Appends one descriptor to the bundle unless it is already full.
  function automatic css_tok_pkg::bundle_t push_desc(input css_tok_pkg::bundle_t bin,
                                                     input logic [3:0] k,
                                                     input logic [16:0] st,
                                                     input logic [16:0] len);
    css_tok_pkg::bundle_t r;
    r = bin;
    if (r.count != 2'(css_tok_pkg::MaxDesc)) begin
      r.slot[r.count].kind   = k;
      r.slot[r.count].start  = st[15:0];
      r.slot[r.count].length = len;
      r.count                = r.count + 2'd1;
    end
    return r;
  endfunction

  always_comb begin
    b      = req_i.char_code;
    mode_d = mode_q;
    pend_d = css_tok_pkg::PEND_NONE;
    poff_d = poff_q;
    rs_d   = rs_q;
    bd     = '0;
    do_vmore = 1'b0;
    do_start = 1'b0;

    // The position counter saturates at the end of the offset range.
    if (pos_q >= PosLimit) begin
      p     = PosLimit;
      pos_d = PosLimit;
      ovf_d = 1'b1;
    end else begin
      p     = pos_q;
      pos_d = pos_q + 17'd1;
      ovf_d = ovf_q;
    end

    case (pend_q)
      css_tok_pkg::PEND_SLASH: begin
        if (b == css_tok_pkg::ChStar) begin
          mode_d = css_tok_pkg::MODE_COMMENT;
        end else begin
          mode_d   = css_tok_pkg::MODE_VALUE;
          rs_d     = poff_q;
          do_vmore = 1'b1;
        end
      end
      css_tok_pkg::PEND_DOT_IDLE: begin
        if (is_digit(b)) begin
          mode_d = css_tok_pkg::MODE_VALUE;
          rs_d   = poff_q;
        end else begin
          bd       = push_desc(bd, css_tok_pkg::KindDot, poff_q, 17'd1);
          do_start = 1'b1;
        end
      end
      css_tok_pkg::PEND_DOT_VALUE: begin
        if (!is_digit(b)) begin
          bd       = push_desc(bd, css_tok_pkg::KindValue, rs_q, poff_q - rs_q);
          bd       = push_desc(bd, css_tok_pkg::KindDot, poff_q, 17'd1);
          do_start = 1'b1;
        end
      end
      default: begin
        case (mode_q)
          css_tok_pkg::MODE_IDENT: begin
            if (!ident_char(b)) begin
              bd       = push_desc(bd, css_tok_pkg::KindIdent, rs_q, p - rs_q);
              do_start = 1'b1;
            end
          end
          css_tok_pkg::MODE_VALUE: begin
            do_vmore = 1'b1;
          end
          css_tok_pkg::MODE_COMMENT: begin
            if (b == css_tok_pkg::ChStar) begin
              mode_d = css_tok_pkg::MODE_STAR;
            end
          end
          css_tok_pkg::MODE_STAR: begin
            if (b == css_tok_pkg::ChSlash) begin
              mode_d = css_tok_pkg::MODE_IDLE;
            end else if (b == css_tok_pkg::ChStar) begin
              mode_d = css_tok_pkg::MODE_STAR;
            end else begin
              mode_d = css_tok_pkg::MODE_COMMENT;
            end
          end
          default: begin
            do_start = 1'b1;
          end
        endcase
      end
    endcase

    // Continuation of a value run.
    if (do_vmore) begin
      if (b == css_tok_pkg::ChDot) begin
        pend_d = css_tok_pkg::PEND_DOT_VALUE;
        poff_d = p;
      end else if (!value_char(b)) begin
        bd       = push_desc(bd, css_tok_pkg::KindValue, rs_d, p - rs_d);
        do_start = 1'b1;
      end
    end

    // Fresh scan of a byte between tokens.
    if (do_start) begin
      mode_d = css_tok_pkg::MODE_IDLE;
      if (!is_space(b)) begin
        if (b == css_tok_pkg::ChSlash) begin
          pend_d = css_tok_pkg::PEND_SLASH;
          poff_d = p;
        end else if (b == css_tok_pkg::ChDot) begin
          pend_d = css_tok_pkg::PEND_DOT_IDLE;
          poff_d = p;
        end else if (punct_hit(b)) begin
          bd = push_desc(bd, punct_kind(b), p, 17'd1);
        end else if (ident_start(b)) begin
          mode_d = css_tok_pkg::MODE_IDENT;
          rs_d   = p;
        end else begin
          mode_d = css_tok_pkg::MODE_VALUE;
          rs_d   = p;
        end
      end
    end

    // Flush whatever is still open at the end of the source.
    if (req_i.end_of_source) begin
      case (pend_d)
        css_tok_pkg::PEND_SLASH: begin
          bd = push_desc(bd, css_tok_pkg::KindValue, poff_d, 17'd1);
        end
        css_tok_pkg::PEND_DOT_IDLE: begin
          bd = push_desc(bd, css_tok_pkg::KindDot, poff_d, 17'd1);
        end
        css_tok_pkg::PEND_DOT_VALUE: begin
          bd = push_desc(bd, css_tok_pkg::KindValue, rs_d, poff_d - rs_d);
          bd = push_desc(bd, css_tok_pkg::KindDot, poff_d, 17'd1);
        end
        default: begin
          if (mode_d == css_tok_pkg::MODE_VALUE) begin
            bd = push_desc(bd, css_tok_pkg::KindValue, rs_d, p + 17'd1 - rs_d);
          end else if (mode_d == css_tok_pkg::MODE_IDENT) begin
            bd = push_desc(bd, css_tok_pkg::KindIdent, rs_d, p + 17'd1 - rs_d);
          end
        end
      endcase
    end

    bd.too_long = ovf_d;
  end

  assign bundle_o = bd;
  assign push_o   = accept_i && (bd.count != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= css_tok_pkg::MODE_IDLE;
      pend_q <= css_tok_pkg::PEND_NONE;
      poff_q <= '0;
      rs_q   <= '0;
      pos_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (accept_i) begin
      if (req_i.end_of_source) begin
        mode_q <= css_tok_pkg::MODE_IDLE;
        pend_q <= css_tok_pkg::PEND_NONE;
        poff_q <= '0;
        rs_q   <= '0;
        pos_q  <= '0;
        ovf_q  <= 1'b0;
      end else begin
        mode_q <= mode_d;
        pend_q <= pend_d;
        poff_q <= poff_d;
        rs_q   <= rs_d;
        pos_q  <= pos_d;
        ovf_q  <= ovf_d;
      end
    end
  end

endmodule

### rtl/core/css_tok_queue.sv
// Small queue of descriptor bundles between front and back ends.
module css_tok_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  css_tok_pkg::bundle_t push_data_i,
  input  logic                 pop_i,
  output css_tok_pkg::bundle_t head_o,
  output css_tok_pkg::q_stat_t stat_o
);

  css_tok_pkg::bundle_t mem_q [css_tok_pkg::QueueDepth];
  logic [css_tok_pkg::QPtrW:0] wr_q, rd_q;

  assign stat_o.empty = (wr_q == rd_q);
  assign stat_o.full  = (wr_q[css_tok_pkg::QPtrW] != rd_q[css_tok_pkg::QPtrW]) &&
                        (wr_q[css_tok_pkg::QPtrW-1:0] == rd_q[css_tok_pkg::QPtrW-1:0]);
  assign head_o = mem_q[rd_q[css_tok_pkg::QPtrW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q[css_tok_pkg::QPtrW-1:0]] <= push_data_i;
    end
  end

endmodule

### rtl/core/css_tok_back.sv
// Back end: unpacks bundles into one descriptor per cycle, while the output is not stalled, on the output register.
module css_tok_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  css_tok_pkg::bundle_t head_i,
  input  css_tok_pkg::q_stat_t stat_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output css_tok_pkg::out_t    out_req_o
);

  logic [1:0]        sel_q;
  logic              valid_q;
  css_tok_pkg::out_t out_q;
  logic              load, is_last;
  css_tok_pkg::desc_t cur;

  assign load    = !valid_q || out_ready_i;
  assign is_last = (sel_q == (head_i.count - 2'd1));
  assign cur     = head_i.slot[sel_q];
  assign pop_o   = load && !stat_i.empty && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= '0;
    end else if (load) begin
      valid_q <= !stat_i.empty;
      if (!stat_i.empty) begin
        sel_q <= is_last ? 2'd0 : sel_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !stat_i.empty) begin
      out_q.token_kind   <= cur.kind;
      out_q.start_offset <= cur.start;
      out_q.token_length <= cur.length;
      out_q.last_of_run  <= is_last;
      out_q.too_long     <= head_i.too_long;
    end
  end

  assign out_valid_o = valid_q;
  assign out_req_o   = out_q;

endmodule

### rtl/core/css_subset_tokenizer.sv
// A descriptor reaches out_valid_o through the bundle queue and then the back end's output register.
// One source byte per cycle while the queue has room; descriptors leave at one per
// cycle while out_ready_i is high, so a byte that causes two or three of them holds the output longer.
// A four-entry bundle queue between scanner and output absorbs such bursts.
// Reset clears the scanner to idle, the queue to empty and the output to invalid.
// After a byte marked end_of_source the scanner is back in its reset state.
`include "css_subset_tokenizer_defines.svh"

module css_subset_tokenizer #(
  parameter int unsigned MAX_SOURCE = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  css_tok_pkg::in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output css_tok_pkg::out_t out_req_o
);

  // The front end scans every accepted request in the cycle it arrives and
  // writes the resulting descriptors, if any, as one bundle into the queue.
  // A request that only skips whitespace or comment text produces no bundle.
  logic                 accept;
  logic                 push;
  logic                 pop;
  css_tok_pkg::bundle_t push_bundle;
  css_tok_pkg::bundle_t head_bundle;
  css_tok_pkg::q_stat_t q_stat;

  // Input is taken whenever the queue has room, independent of the output side.
  assign in_ready_o = !q_stat.full;
  assign accept     = in_valid_i && in_ready_o;

  css_tok_front #(
    .MAX_SOURCE(MAX_SOURCE)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (in_req_i),
    .push_o   (push),
    .bundle_o (push_bundle)
  );

  css_tok_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_bundle),
    .pop_i       (pop),
    .head_o      (head_bundle),
    .stat_o      (q_stat)
  );

  // The back end walks the head bundle one descriptor per cycle, while out_ready_i allows, into its
  // output register and releases the bundle with its last descriptor.
  css_tok_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_bundle),
    .stat_i      (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

  `CSS_TOK_ASSERT_ALWAYS(a_no_push_full, !(push && q_stat.full), "push into full queue")
  `CSS_TOK_ASSERT_ALWAYS(a_no_pop_empty, !(pop && q_stat.empty), "pop from empty queue")
  `CSS_TOK_ASSERT(a_len_nonzero, (out_valid_o && !out_req_o.too_long) |-> (out_req_o.token_length != 17'd0), "zero length token in range")
  `CSS_TOK_ASSERT(a_push_count, push |-> (push_bundle.count != 2'd0), "empty bundle pushed")

endmodule

### dv/tb.sv
// Self-checking testbench for the CSS subset tokenizer, with its own token predictor.
module tb;
  import css_tok_pkg::*;

  // The instance keeps the default source range, so the offset range is the full 16 bits.
  localparam int unsigned SrcCap   = 65536;
  localparam int unsigned PosLimit = (SrcCap < 65536) ? SrcCap : 65536;
  // Random source bytes that carry content; blanks are not counted.
  localparam int unsigned RandItems = 180;
  // The last requests of the random part run with no idling on either side.
  localparam int unsigned CalmItems = 40;

  // Marker for a byte that is not punctuation, and for table rows with no typed result.
  localparam logic [3:0] KindNone = 4'hF;

  // Character codes that the package does not name.
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChTop    = 8'hFF;

  // One row of the directed table. A typed row carries one descriptor that can be
  // read off by eye: always one byte long, last of its run, offsets in range.
  typedef struct packed {
    logic [7:0]  ch;
    logic        eos;
    logic        typed;
    logic [3:0]  kind;
    logic [15:0] at;
  } plan_row_t;

  // Directed sources. The first one walks value runs with a slash, 0x00 and a
  // number with a dot inside it, a dot that ends a value run, every punctuation
  // kind, a comment whose opening star cannot close it, a lone dot and a slash
  // at the end. Then short sources cover a dot at the end, a dot that ends a
  // value run at the end, an identifier cut by a comment that is never closed,
  // and an identifier at the end.
  localparam plan_row_t Plan [28] = '{
    '{ChLbrace, 1'b0, 1'b1, KindLbrace, 16'd0},
    '{ChNul,    1'b0, 1'b0, KindNone,   16'd0},
    '{ChSlash,  1'b0, 1'b0, KindNone,   16'd0},
    '{ChDot,    1'b0, 1'b0, KindNone,   16'd0},
    '{8'h35,    1'b0, 1'b0, KindNone,   16'd0},
    '{ChDot,    1'b0, 1'b0, KindNone,   16'd0},
    '{ChLowerA, 1'b0, 1'b0, KindNone,   16'd0},
    '{ChHash,   1'b0, 1'b0, KindNone,   16'd0},
    '{ChColon,  1'b0, 1'b0, KindNone,   16'd0},
    '{ChComma,  1'b0, 1'b0, KindNone,   16'd0},
    '{ChSemi,   1'b0, 1'b0, KindNone,   16'd0},
    '{ChSlash,  1'b0, 1'b0, KindNone,   16'd0},
    '{ChStar,   1'b0, 1'b0, KindNone,   16'd0},
    '{ChSlash,  1'b0, 1'b0, KindNone,   16'd0},
    '{ChStar,   1'b0, 1'b0, KindNone,   16'd0},
    '{ChStar,   1'b0, 1'b0, KindNone,   16'd0},
    '{ChSlash,  1'b0, 1'b0, KindNone,   16'd0},
    '{ChDot,    1'b0, 1'b0, KindNone,   16'd0},
    '{ChRbrace, 1'b0, 1'b0, KindNone,   16'd0},
    '{ChSlash,  1'b1, 1'b1, KindValue,  16'd19},
    '{ChDot,    1'b1, 1'b1, KindDot,    16'd0},
    '{8'h37,    1'b0, 1'b0, KindNone,   16'd0},
    '{ChDot,    1'b1, 1'b0, KindNone,   16'd0},
    '{ChMinus,  1'b0, 1'b0, KindNone,   16'd0},
    '{ChSlash,  1'b0, 1'b0, KindNone,   16'd0},
    '{ChStar,   1'b0, 1'b0, KindNone,   16'd0},
    '{ChTop,    1'b1, 1'b0, KindNone,   16'd0},
    '{ChUnder,  1'b1, 1'b1, KindIdent,  16'd0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_req;
  logic out_valid;
  logic out_ready;
  out_t out_req;

  // Idling control: calm turns idling off for the tail of the run.
  logic calm;

  int unsigned err_count = 0;
  int unsigned desc_seen = 0;

  // Tokenizer state as the predictor sees it.
  mode_e       tk_mode;
  pend_e       tk_pend;
  logic [16:0] tk_pend_at;
  logic [16:0] tk_run_at;
  logic [16:0] tk_pos;
  logic        tk_over;

  // Descriptors that the byte at hand causes, and all descriptors still due.
  out_t       byte_desc_q[$];
  out_t       want_desc_q[$];
  logic [7:0] draft_q[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  css_subset_tokenizer #(
    .MAX_SOURCE(SrcCap)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_req_o  (out_req)
  );

  // ---------------------------------------------------------------------------
  // Character classes.
  // ---------------------------------------------------------------------------

  // C-locale whitespace: space, tab, LF, VT, FF and CR.
  function automatic logic is_blank(logic [7:0] b);
    return b == ChSpace || (b >= ChTab && b <= 8'h0D);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= ChDigit0 && b <= ChDigit0 + 8'd9;
  endfunction

  function automatic logic word_start(logic [7:0] b);
    return (b >= ChLowerA && b <= ChLowerA + 8'd25) || (b >= ChUpperA && b <= ChUpperA + 8'd25)
        || b == ChUnder || b == ChMinus;
  endfunction

  function automatic logic word_char(logic [7:0] b);
    return word_start(b) || is_digit(b);
  endfunction

  function automatic logic [3:0] punct_kind_of(logic [7:0] b);
    case (b)
      ChDot:    return KindDot;
      ChHash:   return KindHash;
      ChColon:  return KindColon;
      ChComma:  return KindComma;
      ChSemi:   return KindSemi;
      ChLbrace: return KindLbrace;
      ChRbrace: return KindRbrace;
      default:  return KindNone;
    endcase
  endfunction

  // Everything that is neither blank nor punctuation extends a value run,
  // including slash, star and every byte from 128 up.
  function automatic logic is_value_byte(logic [7:0] b);
    return punct_kind_of(b) == KindNone && !is_blank(b);
  endfunction

  // ---------------------------------------------------------------------------
  // Token predictor.
  // ---------------------------------------------------------------------------

  function automatic void restore_scanner();
    tk_mode    = MODE_IDLE;
    tk_pend    = PEND_NONE;
    tk_pend_at = '0;
    tk_run_at  = '0;
    tk_pos     = '0;
    tk_over    = 1'b0;
  endfunction

  // Offsets and lengths are kept at 17 bits so a saturated position survives;
  // the descriptor then carries them masked to the field widths.
  function automatic void note_desc(logic [3:0] kind, logic [16:0] at, logic [16:0] len);
    out_t d;
    if (byte_desc_q.size() >= MaxDesc) return;
    d.token_kind   = kind;
    d.start_offset = at[15:0];
    d.token_length = len;
    d.last_of_run  = 1'b0;
    d.too_long     = 1'b0;
    byte_desc_q.insert(byte_desc_q.size(), d);
  endfunction

  // Treats b as the first byte of a new token.
  function automatic void scan_fresh(logic [7:0] b, logic [16:0] p);
    tk_mode = MODE_IDLE;
    if (is_blank(b)) return;
    if (b == ChSlash) begin
      tk_pend    = PEND_SLASH;
      tk_pend_at = p;
    end else if (b == ChDot) begin
      tk_pend    = PEND_DOT_IDLE;
      tk_pend_at = p;
    end else if (punct_kind_of(b) != KindNone) begin
      note_desc(punct_kind_of(b), p, 17'd1);
    end else if (word_start(b)) begin
      tk_mode   = MODE_IDENT;
      tk_run_at = p;
    end else begin
      tk_mode   = MODE_VALUE;
      tk_run_at = p;
    end
  endfunction

  function automatic void value_extend(logic [7:0] b, logic [16:0] p);
    if (b == ChDot) begin
      tk_pend    = PEND_DOT_VALUE;
      tk_pend_at = p;
    end else if (!is_value_byte(b)) begin
      note_desc(KindValue, tk_run_at, p - tk_run_at);
      scan_fresh(b, p);
    end
  endfunction

  // Advances the predictor by one source byte and leaves the descriptors it
  // causes in byte_desc_q.
  function automatic void tokenize_byte(logic [7:0] b, logic eos);
    logic [16:0] p;
    pend_e       held;
    p    = tk_pos;
    held = tk_pend;
    byte_desc_q.delete();
    // The position saturates at the end of the offset range and the overflow
    // flag sticks until the end of the source.
    if (p >= PosLimit) begin
      tk_over = 1'b1;
      p       = PosLimit;
      tk_pos  = PosLimit;
    end else begin
      tk_pos = p + 17'd1;
    end

    tk_pend = PEND_NONE;
    case (held)
      PEND_SLASH: begin
        if (b == ChStar) begin
          tk_mode = MODE_COMMENT;
        end else begin
          tk_mode   = MODE_VALUE;
          tk_run_at = tk_pend_at;
          value_extend(b, p);
        end
      end
      PEND_DOT_IDLE: begin
        if (is_digit(b)) begin
          tk_mode   = MODE_VALUE;
          tk_run_at = tk_pend_at;
        end else begin
          note_desc(KindDot, tk_pend_at, 17'd1);
          scan_fresh(b, p);
        end
      end
      PEND_DOT_VALUE: begin
        if (!is_digit(b)) begin
          note_desc(KindValue, tk_run_at, tk_pend_at - tk_run_at);
          note_desc(KindDot, tk_pend_at, 17'd1);
          scan_fresh(b, p);
        end
      end
      default: begin
        case (tk_mode)
          MODE_IDENT: begin
            if (!word_char(b)) begin
              note_desc(KindIdent, tk_run_at, p - tk_run_at);
              scan_fresh(b, p);
            end
          end
          MODE_VALUE: value_extend(b, p);
          MODE_COMMENT: begin
            if (b == ChStar) tk_mode = MODE_STAR;
          end
          MODE_STAR: begin
            if (b == ChSlash) tk_mode = MODE_IDLE;
            else if (b != ChStar) tk_mode = MODE_COMMENT;
          end
          default: scan_fresh(b, p);
        endcase
      end
    endcase

    // The last byte flushes whatever is still open.
    if (eos) begin
      case (tk_pend)
        PEND_SLASH:    note_desc(KindValue, tk_pend_at, 17'd1);
        PEND_DOT_IDLE: note_desc(KindDot, tk_pend_at, 17'd1);
        PEND_DOT_VALUE: begin
          note_desc(KindValue, tk_run_at, tk_pend_at - tk_run_at);
          note_desc(KindDot, tk_pend_at, 17'd1);
        end
        default: begin
          if (tk_mode == MODE_VALUE) note_desc(KindValue, tk_run_at, p + 17'd1 - tk_run_at);
          else if (tk_mode == MODE_IDENT) note_desc(KindIdent, tk_run_at, p + 17'd1 - tk_run_at);
        end
      endcase
    end

    foreach (byte_desc_q[k]) begin
      byte_desc_q[k].last_of_run = (k == byte_desc_q.size() - 1);
      byte_desc_q[k].too_long    = tk_over;
    end
    if (eos) restore_scanner();
  endfunction

  // ---------------------------------------------------------------------------
  // Random source text.
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pick_letter();
    return ($urandom_range(0, 1) == 0 ? ChLowerA : ChUpperA) + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pick_digit();
    return ChDigit0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_word_byte(logic first);
    case ($urandom_range(0, 5))
      0:       return ChUnder;
      1:       return ChMinus;
      2:       return first ? pick_letter() : pick_digit();
      default: return pick_letter();
    endcase
  endfunction

  // A byte weighted toward what matters to the scanner, with a share of
  // fully random bytes so every code shows up.
  function automatic logic [7:0] pick_css_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 18) return pick_letter();
    if (r < 28) return pick_digit();
    if (r < 32) return $urandom_range(0, 1) == 0 ? ChUnder : ChMinus;
    if (r < 46) begin
      case ($urandom_range(0, 6))
        0:       return ChDot;
        1:       return ChHash;
        2:       return ChColon;
        3:       return ChComma;
        4:       return ChSemi;
        5:       return ChLbrace;
        default: return ChRbrace;
      endcase
    end
    if (r < 52) return ChDot;
    if (r < 58) return ChSlash;
    if (r < 63) return ChStar;
    if (r < 75) return $urandom_range(0, 5) == 0 ? ChSpace : ChTab + 8'($urandom_range(0, 4));
    if (r < 85) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  // Appends one byte to the source being built.
  function automatic void add_byte(logic [7:0] c);
    draft_q.insert(draft_q.size(), c);
  endfunction

  // Builds one source in draft_q from comments, numbers, identifiers and loose bytes.
  function automatic void compose_source();
    draft_q.delete();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 9))
        0: begin
          // Block comment, now and then left open to the end of the source.
          add_byte(ChSlash);
          add_byte(ChStar);
          repeat ($urandom_range(0, 4)) add_byte(pick_css_byte());
          if ($urandom_range(0, 3) != 0) begin
            add_byte(ChStar);
            add_byte(ChSlash);
          end
        end
        1, 2: begin
          // Numbers such as 12, .5, 3. and 1.25.
          if ($urandom_range(0, 2) == 0) add_byte(ChDot);
          repeat ($urandom_range(1, 3)) add_byte(pick_digit());
          if ($urandom_range(0, 1) == 0) begin
            add_byte(ChDot);
            repeat ($urandom_range(0, 2)) add_byte(pick_digit());
          end
        end
        3, 4: begin
          add_byte(pick_word_byte(1'b1));
          repeat ($urandom_range(0, 5)) add_byte(pick_word_byte(1'b0));
        end
        default: begin
          repeat ($urandom_range(1, 3)) add_byte(pick_css_byte());
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking.
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Presents one byte as a request, starting and ending at a falling edge. A
  // typed table row replaces the predicted descriptors by the one it carries;
  // the predictor still advances so that later rows stay in step.
  task automatic feed(input logic [7:0] ch, input logic eos, input logic typed = 1'b0,
                      input logic [3:0] kind = KindNone, input logic [15:0] at = '0);
    out_t typed_d;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{char_code: ch, end_of_source: eos};
    do @(posedge clk); while (!in_ready);
    tokenize_byte(ch, eos);
    if (typed) begin
      typed_d.token_kind   = kind;
      typed_d.start_offset = at;
      typed_d.token_length = 17'd1;
      typed_d.last_of_run  = 1'b1;
      typed_d.too_long     = 1'b0;
      want_desc_q.insert(want_desc_q.size(), typed_d);
    end else begin
      foreach (byte_desc_q[k]) want_desc_q.insert(want_desc_q.size(), byte_desc_q[k]);
    end
    @(negedge clk);
  endtask

  // Every accepted descriptor is checked against the oldest one still due.
  always @(posedge clk) begin
    out_t exp_d;
    if (rst_n && out_valid && out_ready) begin
      desc_seen++;
      if (want_desc_q.size() == 0) begin
        flag_mismatch($sformatf("descriptor %0d arrived with none due", desc_seen));
      end else begin
        exp_d = want_desc_q.pop_front();
        if (out_req.token_kind !== exp_d.token_kind)
          flag_mismatch($sformatf("descriptor %0d token_kind %0d, want %0d",
                                  desc_seen, out_req.token_kind, exp_d.token_kind));
        if (out_req.start_offset !== exp_d.start_offset)
          flag_mismatch($sformatf("descriptor %0d start_offset %0d, want %0d",
                                  desc_seen, out_req.start_offset, exp_d.start_offset));
        if (out_req.token_length !== exp_d.token_length)
          flag_mismatch($sformatf("descriptor %0d token_length %0d, want %0d",
                                  desc_seen, out_req.token_length, exp_d.token_length));
        if (out_req.last_of_run !== exp_d.last_of_run)
          flag_mismatch($sformatf("descriptor %0d last_of_run %0b, want %0b",
                                  desc_seen, out_req.last_of_run, exp_d.last_of_run));
        if (out_req.too_long !== exp_d.too_long)
          flag_mismatch($sformatf("descriptor %0d too_long %0b, want %0b",
                                  desc_seen, out_req.too_long, exp_d.too_long));
      end
    end
  end

  // The receiver stalls in random bursts until the calm tail of the run.
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    int unsigned rand_bytes;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_req     = '0;
    calm       = 1'b0;
    rand_bytes = 0;
    restore_scanner();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (Plan[i]) feed(Plan[i].ch, Plan[i].eos, Plan[i].typed, Plan[i].kind, Plan[i].at);

    // Random sources, each closed by its end-of-source byte.
    while (rand_bytes < RandItems) begin
      compose_source();
      foreach (draft_q[k]) begin
        calm = (rand_bytes >= RandItems - CalmItems);
        feed(draft_q[k], k == draft_q.size() - 1);
        if (!is_blank(draft_q[k])) rand_bytes++;
      end
    end
    in_valid <= 1'b0;

    // Drain, then keep watching for any stray descriptor to show.
    while (want_desc_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("css_subset_tokenizer verification clean");
    end else begin
      $display("css_subset_tokenizer verification failed");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #1000000;
    $display("css_subset_tokenizer verification failed");
    $finish;
  end

endmodule
